[rtl/core/assert_macros.svh]
// Assertion helpers used by the allocator back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define FFHA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define FFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/ffha_pkg.sv]
package ffha_pkg;

   localparam int MAX_EXTENTS   = 64;
   localparam int IDX_W         = $clog2(MAX_EXTENTS);
   localparam int CNT_W         = IDX_W + 1;
   localparam int SZ_W          = 21;
   localparam int ADDR_W        = 32;
   localparam int MIN_REMAINDER = 16;
   localparam int MIN_POOL      = 48;
   localparam int CSR_W         = 2;

   localparam logic [CSR_W-1:0] CSR_POOL_BASE = 2'd0;
   localparam logic [CSR_W-1:0] CSR_POOL_SIZE = 2'd1;

   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_BAD_REQ   = 3'd1,
      STAT_NO_MEM    = 3'd2,
      STAT_BAD_BLOCK = 3'd3,
      STAT_OVERLAP   = 3'd4,
      STAT_FULL      = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      OP_ALLOC,
      OP_FREE,
      OP_REJECT
   } op_type;

   // one classified item on its way to the back end
   typedef struct packed {
      op_type           op;
      status_type       status;
      logic [SZ_W-1:0]  size;
      logic [SZ_W-1:0]  off;
   } item_type;

   // pool geometry shared with the front end
   typedef struct packed {
      logic             init_pend;
      logic [ADDR_W:0]  abase;
      logic [SZ_W-1:0]  usable;
   } pool_type;

   typedef struct packed {
      logic [SZ_W-1:0] start;
      logic [SZ_W-1:0] len;
   } extent_type;

   typedef enum logic [3:0] {
      BS_IDLE,
      BS_A_RD,
      BS_A_CHK,
      BS_F_RD,
      BS_F_CHK,
      BS_F_EVAL,
      BS_SD_RD,
      BS_SD_WR,
      BS_SU_RD,
      BS_SU_WR,
      BS_RESP
   } state_type;

endpackage

[rtl/core/first_fit_heap_allocator.sv]
// First-fit heap allocator over 8-byte granules with coalescing on free.
// A rejected item goes straight to the result; allocate walks the extents in order and
// shifts entries down on removal; free walks to the insertion point and shifts entries
// up on insert. The back end handles one item at a time over its extent table (one write
// port, one registered read port); a two-entry queue takes new items meanwhile. Reset
// (synchronous) restores pool base 0 and size 65536; the pool is then laid down as one
// whole extent. Results are one-cycle strobes; the receiver cannot stall.
module first_fit_heap_allocator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_action,
   input  logic [19:0]                   req_size,
   input  logic [ffha_pkg::ADDR_W-1:0]   req_addr,
   input  logic [ffha_pkg::SZ_W-1:0]     req_block_size,
   output logic                          rsp_valid,
   output logic [2:0]                    rsp_status,
   output logic [ffha_pkg::ADDR_W-1:0]   rsp_granted_addr,
   output logic [ffha_pkg::SZ_W-1:0]     rsp_granted_size,
   output logic [ffha_pkg::SZ_W-1:0]     rsp_free_total,
   input  logic                          csr_we,
   input  logic [ffha_pkg::CSR_W-1:0]    csr_index,
   input  logic [31:0]                   csr_wdata
);

   ffha_pkg::pool_type pool;
   ffha_pkg::item_type head;
   logic               q_valid;
   logic               pop;

   ffha_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_size       (req_size),
      .req_addr       (req_addr),
      .req_block_size (req_block_size),
      .pool           (pool),
      .pop            (pop),
      .q_valid        (q_valid),
      .head           (head)
   );

   ffha_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .q_valid          (q_valid),
      .head             (head),
      .pop              (pop),
      .pool             (pool),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_granted_addr (rsp_granted_addr),
      .rsp_granted_size (rsp_granted_size),
      .rsp_free_total   (rsp_free_total)
   );

endmodule

[rtl/core/ffha_ram.sv]
module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/ffha_front.sv]
module ffha_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_action,
   input  logic [19:0]                   req_size,
   input  logic [ffha_pkg::ADDR_W-1:0]   req_addr,
   input  logic [ffha_pkg::SZ_W-1:0]     req_block_size,
   input  ffha_pkg::pool_type            pool,
   input  logic                          pop,
   output logic                          q_valid,
   output ffha_pkg::item_type            head
);

   ffha_pkg::item_type q_ff [2];
   logic               wp_ff, wp_in;
   logic               rp_ff, rp_in;
   logic [1:0]         cnt_ff, cnt_in;
   ffha_pkg::item_type cls;
   logic               push;
   logic [ffha_pkg::SZ_W-1:0]   need;
   logic [ffha_pkg::ADDR_W:0]   habs;
   logic [ffha_pkg::ADDR_W:0]   rel;
   logic                        bad;

   assign busy    = (cnt_ff == 2'd2) | pool.init_pend;
   assign push    = start & ~busy;
   assign q_valid = (cnt_ff != 2'd0);
   assign head    = q_ff[rp_ff];

   // classify: size rounding and zero check for allocate, range, alignment and minimum size for free
   always_comb begin
      need = ffha_pkg::SZ_W'(({1'b0, req_size} + 21'd7) & ~21'd7) + 21'd8;
      habs = {1'b0, req_addr} - 33'd8;
      rel  = habs - pool.abase;
      bad  = (req_addr < 32'd8) || (req_block_size[2:0] != 3'd0) ||
             (req_block_size < 21'd16) || (habs < pool.abase) || (rel[2:0] != 3'd0) ||
             (({1'b0, rel} + 34'(req_block_size)) > 34'(pool.usable));
      cls.off    = rel[ffha_pkg::SZ_W-1:0];
      cls.status = ffha_pkg::STAT_OK;
      if (req_action == 1'b0) begin
         cls.size = need;
         if (req_size == 20'd0) begin
            cls.op     = ffha_pkg::OP_REJECT;
            cls.status = ffha_pkg::STAT_BAD_REQ;
         end else begin
            cls.op = ffha_pkg::OP_ALLOC;
         end
      end else begin
         cls.size = req_block_size;
         if (bad) begin
            cls.op     = ffha_pkg::OP_REJECT;
            cls.status = ffha_pkg::STAT_BAD_BLOCK;
         end else begin
            cls.op = ffha_pkg::OP_FREE;
         end
      end
   end

   // two-entry queue pointers
   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= cls;
      end
   end

endmodule

[rtl/core/ffha_back.sv]
`include "assert_macros.svh"

module ffha_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [ffha_pkg::CSR_W-1:0]    csr_index,
   input  logic [31:0]                   csr_wdata,
   input  logic                          q_valid,
   input  ffha_pkg::item_type            head,
   output logic                          pop,
   output ffha_pkg::pool_type            pool,
   output logic                          rsp_valid,
   output logic [2:0]                    rsp_status,
   output logic [ffha_pkg::ADDR_W-1:0]   rsp_granted_addr,
   output logic [ffha_pkg::SZ_W-1:0]     rsp_granted_size,
   output logic [ffha_pkg::SZ_W-1:0]     rsp_free_total
);

   localparam int SW = ffha_pkg::SZ_W;
   localparam int CW = ffha_pkg::CNT_W;
   localparam int IW = ffha_pkg::IDX_W;

   ffha_pkg::state_type  state_ff, state_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [SW-1:0]        free_ff, free_in;
   logic [32:0]          abase_ff, abase_in;
   logic [SW-1:0]        usable_ff, usable_in;
   logic                 init_ff, init_in;
   logic [31:0]          pbase_ff, pbase_in;
   logic [SW-1:0]        psize_ff, psize_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        k_ff, k_in;
   ffha_pkg::item_type   item_ff, item_in;
   logic                 pv_ff, pv_in;
   ffha_pkg::extent_type prv_ff, prv_in;
   logic                 nv_ff, nv_in;
   ffha_pkg::extent_type nxt_ff, nxt_in;
   ffha_pkg::status_type hst_ff, hst_in;
   logic [31:0]          hga_ff, hga_in;
   logic [SW-1:0]        hgs_ff, hgs_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           rsp_status_ff, rsp_status_in;
   logic [31:0]          rsp_ga_ff, rsp_ga_in;
   logic [SW-1:0]        rsp_gs_ff, rsp_gs_in;
   logic [SW-1:0]        rsp_ft_ff, rsp_ft_in;

   logic                 ram_we;
   logic [IW-1:0]        ram_waddr, ram_raddr;
   ffha_pkg::extent_type ram_wdata, rd;

   logic [32:0]          ini_ab;
   logic [2:0]           ini_adj;
   logic [SW-1:0]        ini_u;
   logic [32:0]          ini_room;
   logic [SW:0]          pend, fend;
   logic                 pa, na;

   ffha_ram #(.WIDTH($bits(ffha_pkg::extent_type)), .DEPTH(ffha_pkg::MAX_EXTENTS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (rd)
   );

   assign pool.init_pend = init_ff;
   assign pool.abase     = abase_ff;
   assign pool.usable    = usable_ff;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_granted_addr = rsp_ga_ff;
   assign rsp_granted_size = rsp_gs_ff;
   assign rsp_free_total   = rsp_ft_ff;

   // pool geometry from the configuration registers
   always_comb begin
      ini_ab   = ({1'b0, pbase_ff} + 33'd7) & ~33'd7;
      ini_adj  = 3'(3'd0 - pbase_ff[2:0]);
      ini_u    = '0;
      if ((psize_ff >= SW'(ffha_pkg::MIN_POOL)) && (psize_ff >= SW'(ini_adj))) begin
         ini_u = (psize_ff - SW'(ini_adj)) & ~SW'(7);
      end
      ini_room = 33'h1_0000_0000 - ini_ab;
      if (ini_ab[32]) begin
         ini_u = '0;
      end else if (33'(ini_u) > ini_room) begin
         ini_u = ini_room[SW-1:0];
      end
   end

   // neighbor arithmetic for free
   always_comb begin
      pend = {1'b0, prv_ff.start} + {1'b0, prv_ff.len};
      fend = {1'b0, item_ff.off} + {1'b0, item_ff.size};
      pa   = pv_ff && (pend == {1'b0, item_ff.off});
      na   = nv_ff && ({1'b0, nxt_ff.start} == fend);
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      free_in       = free_ff;
      abase_in      = abase_ff;
      usable_in     = usable_ff;
      init_in       = init_ff;
      pbase_in      = pbase_ff;
      psize_in      = psize_ff;
      idx_in        = idx_ff;
      k_in          = k_ff;
      item_in       = item_ff;
      pv_in         = pv_ff;
      prv_in        = prv_ff;
      nv_in         = nv_ff;
      nxt_in        = nxt_ff;
      hst_in        = hst_ff;
      hga_in        = hga_ff;
      hgs_in        = hgs_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_ga_in     = rsp_ga_ff;
      rsp_gs_in     = rsp_gs_ff;
      rsp_ft_in     = rsp_ft_ff;
      pop           = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff[IW-1:0];
      ram_wdata     = rd;
      ram_raddr     = idx_ff[IW-1:0];

      case (state_ff)
         ffha_pkg::BS_IDLE: begin
            if (init_ff) begin
               // lay down one whole-pool extent
               init_in         = 1'b0;
               abase_in        = ini_ab;
               usable_in       = ini_u;
               free_in         = ini_u;
               cnt_in          = CW'(ini_u != '0);
               ram_we          = 1'b1;
               ram_waddr       = '0;
               ram_wdata.start = '0;
               ram_wdata.len   = ini_u;
            end else if (q_valid) begin
               pop     = 1'b1;
               item_in = head;
               hst_in  = head.status;
               hga_in  = '0;
               hgs_in  = '0;
               idx_in  = '0;
               pv_in   = 1'b0;
               case (head.op)
                  ffha_pkg::OP_ALLOC: begin
                     if (cnt_ff == '0) begin
                        hst_in   = ffha_pkg::STAT_NO_MEM;
                        state_in = ffha_pkg::BS_RESP;
                     end else begin
                        state_in = ffha_pkg::BS_A_RD;
                     end
                  end
                  ffha_pkg::OP_FREE: state_in = ffha_pkg::BS_F_RD;
                  default:           state_in = ffha_pkg::BS_RESP;
               endcase
            end
         end

         ffha_pkg::BS_A_RD: begin
            state_in = ffha_pkg::BS_A_CHK;
         end

         // first fit test on the extent just read
         ffha_pkg::BS_A_CHK: begin
            if (rd.len >= item_ff.size) begin
               hga_in = abase_ff[31:0] + 32'(rd.start) + 32'd8;
               if ((rd.len - item_ff.size) >= SW'(ffha_pkg::MIN_REMAINDER)) begin
                  ram_we          = 1'b1;
                  ram_wdata.start = rd.start + item_ff.size;
                  ram_wdata.len   = rd.len - item_ff.size;
                  free_in         = free_ff - item_ff.size;
                  hgs_in          = item_ff.size;
                  state_in        = ffha_pkg::BS_RESP;
               end else begin
                  free_in  = free_ff - rd.len;
                  hgs_in   = rd.len;
                  k_in     = idx_ff;
                  state_in = ffha_pkg::BS_SD_RD;
               end
            end else if ((idx_ff + CW'(1)) >= cnt_ff) begin
               hst_in   = ffha_pkg::STAT_NO_MEM;
               state_in = ffha_pkg::BS_RESP;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = ffha_pkg::BS_A_RD;
            end
         end

         // walk to the first extent at or above the freed block
         ffha_pkg::BS_F_RD: begin
            if (idx_ff == cnt_ff) begin
               nv_in    = 1'b0;
               state_in = ffha_pkg::BS_F_EVAL;
            end else begin
               state_in = ffha_pkg::BS_F_CHK;
            end
         end

         ffha_pkg::BS_F_CHK: begin
            if (rd.start >= item_ff.off) begin
               nv_in    = 1'b1;
               nxt_in   = rd;
               state_in = ffha_pkg::BS_F_EVAL;
            end else begin
               pv_in    = 1'b1;
               prv_in   = rd;
               idx_in   = idx_ff + CW'(1);
               state_in = ffha_pkg::BS_F_RD;
            end
         end

         // overlap check, then merge, insert or report a full table
         ffha_pkg::BS_F_EVAL: begin
            state_in = ffha_pkg::BS_RESP;
            if ((nv_ff && ({1'b0, nxt_ff.start} < fend)) ||
                (pv_ff && (pend > {1'b0, item_ff.off}))) begin
               hst_in = ffha_pkg::STAT_OVERLAP;
            end else if (pa) begin
               ram_we          = 1'b1;
               ram_waddr       = IW'(idx_ff - CW'(1));
               ram_wdata.start = prv_ff.start;
               ram_wdata.len   = prv_ff.len + item_ff.size + (na ? nxt_ff.len : '0);
               free_in         = free_ff + item_ff.size;
               if (na) begin
                  k_in     = idx_ff;
                  state_in = ffha_pkg::BS_SD_RD;
               end
            end else if (na) begin
               ram_we          = 1'b1;
               ram_wdata.start = item_ff.off;
               ram_wdata.len   = nxt_ff.len + item_ff.size;
               free_in         = free_ff + item_ff.size;
            end else if (cnt_ff >= CW'(ffha_pkg::MAX_EXTENTS)) begin
               hst_in = ffha_pkg::STAT_FULL;
            end else begin
               free_in  = free_ff + item_ff.size;
               k_in     = cnt_ff;
               state_in = ffha_pkg::BS_SU_RD;
            end
         end

         // close the gap at k, reading entry k+1 and writing it to k
         ffha_pkg::BS_SD_RD: begin
            ram_raddr = IW'(k_ff + CW'(1));
            if ((k_ff + CW'(1)) >= cnt_ff) begin
               cnt_in   = cnt_ff - CW'(1);
               state_in = ffha_pkg::BS_RESP;
            end else begin
               state_in = ffha_pkg::BS_SD_WR;
            end
         end

         ffha_pkg::BS_SD_WR: begin
            ram_we    = 1'b1;
            ram_waddr = k_ff[IW-1:0];
            k_in      = k_ff + CW'(1);
            state_in  = ffha_pkg::BS_SD_RD;
         end

         // open a gap at idx, then drop the new extent in
         ffha_pkg::BS_SU_RD: begin
            ram_raddr = IW'(k_ff - CW'(1));
            if (k_ff == idx_ff) begin
               ram_we          = 1'b1;
               ram_wdata.start = item_ff.off;
               ram_wdata.len   = item_ff.size;
               cnt_in          = cnt_ff + CW'(1);
               state_in        = ffha_pkg::BS_RESP;
            end else begin
               state_in = ffha_pkg::BS_SU_WR;
            end
         end

         ffha_pkg::BS_SU_WR: begin
            ram_we    = 1'b1;
            ram_waddr = k_ff[IW-1:0];
            k_in      = k_ff - CW'(1);
            state_in  = ffha_pkg::BS_SU_RD;
         end

         ffha_pkg::BS_RESP: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = hst_ff;
            rsp_ga_in     = (hst_ff == ffha_pkg::STAT_OK) ? hga_ff : '0;
            rsp_gs_in     = (hst_ff == ffha_pkg::STAT_OK) ? hgs_ff : '0;
            rsp_ft_in     = free_ff;
            state_in      = ffha_pkg::BS_IDLE;
         end

         default: state_in = ffha_pkg::BS_IDLE;
      endcase

      // register writes reinitialise the pool
      if (csr_we) begin
         if (csr_index == ffha_pkg::CSR_POOL_BASE) begin
            pbase_in = csr_wdata;
            init_in  = 1'b1;
         end else if (csr_index == ffha_pkg::CSR_POOL_SIZE) begin
            psize_in = csr_wdata[SW-1:0];
            init_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffha_pkg::BS_IDLE;
         cnt_ff       <= '0;
         free_ff      <= '0;
         abase_ff     <= '0;
         usable_ff    <= '0;
         init_ff      <= 1'b1;
         pbase_ff     <= '0;
         psize_ff     <= 21'd65536;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         free_ff      <= free_in;
         abase_ff     <= abase_in;
         usable_ff    <= usable_in;
         init_ff      <= init_in;
         pbase_ff     <= pbase_in;
         psize_ff     <= psize_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      k_ff          <= k_in;
      item_ff       <= item_in;
      pv_ff         <= pv_in;
      prv_ff        <= prv_in;
      nv_ff         <= nv_in;
      nxt_ff        <= nxt_in;
      hst_ff        <= hst_in;
      hga_ff        <= hga_in;
      hgs_ff        <= hgs_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ga_ff     <= rsp_ga_in;
      rsp_gs_ff     <= rsp_gs_in;
      rsp_ft_ff     <= rsp_ft_in;
   end

   `FFHA_ASSERT(a_cnt_max, cnt_ff <= CW'(ffha_pkg::MAX_EXTENTS), "extent count overflow")
   `FFHA_ASSERT(a_free_le_usable, free_ff <= usable_ff, "free total exceeds pool")
   `FFHA_ASSERT_NEXT(a_pop_idle, pop, state_ff != ffha_pkg::BS_IDLE || rsp_valid_ff,
      "item taken without leaving idle")

endmodule

[test/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE   = 300;
   localparam int WD_LIMIT = 20000;

   typedef struct packed {
      ffha_pkg::status_type st;
      logic [31:0]      ga;
      logic [20:0]      gs;
      logic [20:0]      ft;
   } alloc_rsp_type;

   typedef struct {
      bit               act;
      logic [19:0]      rq;
      logic [31:0]      ad;
      logic [20:0]      bs;
      bit               typed;
      alloc_rsp_type    want;
   } dir_row_type;

   logic          clock;
   logic          reset;
   logic          start;
   logic          busy;
   logic          req_action;
   logic [19:0]   req_size;
   logic [31:0]   req_addr;
   logic [20:0]   req_block_size;
   logic          rsp_valid;
   logic [2:0]    rsp_status;
   logic [31:0]   rsp_granted_addr;
   logic [20:0]   rsp_granted_size;
   logic [20:0]   rsp_free_total;
   logic          csr_we;
   logic [ffha_pkg::CSR_W-1:0] csr_index;
   logic [31:0]   csr_wdata;

   first_fit_heap_allocator dut (.*);

   // pool model state
   logic [31:0]   pool_base_m;
   logic [20:0]   pool_size_m;
   longint unsigned abase_m;
   int unsigned   usable_m;
   int unsigned   ext_start[ffha_pkg::MAX_EXTENTS];
   int unsigned   ext_len[ffha_pkg::MAX_EXTENTS];
   int unsigned   ext_cnt;
   int unsigned   free_m;

   alloc_rsp_type rsp_q[$];
   logic [31:0]   live_addr[$];
   logic [20:0]   live_size[$];
   logic [31:0]   gone_addr;
   logic [20:0]   gone_size;
   int            errors;
   int            n_items;
   int            st_count[8];
   int            n_results;
   bit            idle_on;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // rebuild the single whole-pool extent from the register values
   function automatic void pool_reinit();
      longint unsigned adj, u, room;
      abase_m = (longint'(pool_base_m) + 7) & ~64'd7;
      adj = abase_m - longint'(pool_base_m);
      u = 0;
      if (pool_size_m >= ffha_pkg::MIN_POOL && longint'(pool_size_m) >= adj)
         u = (longint'(pool_size_m) - adj) & ~64'd7;
      room = (abase_m >= 64'h1_0000_0000) ? 0 : ((64'h1_0000_0000 - abase_m) & ~64'd7);
      if (u > room) u = room;
      usable_m = int'(u);
      for (int k = 0; k < ffha_pkg::MAX_EXTENTS; k++) begin
         ext_start[k] = 0;
         ext_len[k] = 0;
      end
      ext_len[0] = usable_m;
      ext_cnt = (usable_m > 0) ? 1 : 0;
      free_m = usable_m;
   endfunction

   function automatic void drop_extent(int unsigned i);
      for (int unsigned k = i; k + 1 < ext_cnt; k++) begin
         ext_start[k] = ext_start[k+1];
         ext_len[k] = ext_len[k+1];
      end
      ext_cnt--;
   endfunction

   function automatic ffha_pkg::status_type pool_alloc(input int unsigned rq,
                                                       output logic [31:0] ga,
                                                       output int unsigned gs);
      int unsigned need, len, off;
      ga = 0;
      gs = 0;
      if (rq == 0) return ffha_pkg::STAT_BAD_REQ;
      need = ((rq + 7) & ~32'd7) + 8;
      for (int unsigned i = 0; i < ext_cnt; i++) begin
         len = ext_len[i];
         if (len >= need) begin
            off = ext_start[i];
            if (len - need >= ffha_pkg::MIN_REMAINDER) begin
               ext_start[i] = off + need;
               ext_len[i] = len - need;
            end else begin
               need = len;
               drop_extent(i);
            end
            free_m -= need;
            ga = 32'(abase_m + off + 8);
            gs = need;
            return ffha_pkg::STAT_OK;
         end
      end
      return ffha_pkg::STAT_NO_MEM;
   endfunction

   function automatic ffha_pkg::status_type pool_free(input logic [31:0] ad,
                                                      input int unsigned sz);
      longint unsigned habs;
      int unsigned off, last, i;
      bit prev_adj, next_adj;
      if (ad < 8 || sz[2:0] != 0 || sz < 16) return ffha_pkg::STAT_BAD_BLOCK;
      habs = longint'(ad) - 8;
      if (habs < abase_m) return ffha_pkg::STAT_BAD_BLOCK;
      if (((habs - abase_m) & 7) != 0) return ffha_pkg::STAT_BAD_BLOCK;
      if (habs - abase_m + sz > usable_m) return ffha_pkg::STAT_BAD_BLOCK;
      off = int'(habs - abase_m);
      last = off + sz;
      for (i = 0; i < ext_cnt; i++)
         if (ext_start[i] >= off) break;
      if (i < ext_cnt && ext_start[i] < last) return ffha_pkg::STAT_OVERLAP;
      if (i > 0 && ext_start[i-1] + ext_len[i-1] > off) return ffha_pkg::STAT_OVERLAP;
      prev_adj = (i > 0) && (ext_start[i-1] + ext_len[i-1] == off);
      next_adj = (i < ext_cnt) && (ext_start[i] == last);
      if (prev_adj && next_adj) begin
         ext_len[i-1] += sz + ext_len[i];
         drop_extent(i);
      end else if (prev_adj) begin
         ext_len[i-1] += sz;
      end else if (next_adj) begin
         ext_start[i] = off;
         ext_len[i] += sz;
      end else begin
         if (ext_cnt >= ffha_pkg::MAX_EXTENTS) return ffha_pkg::STAT_FULL;
         for (int unsigned k = ext_cnt; k > i; k--) begin
            ext_start[k] = ext_start[k-1];
            ext_len[k] = ext_len[k-1];
         end
         ext_start[i] = off;
         ext_len[i] = sz;
         ext_cnt++;
      end
      free_m += sz;
      return ffha_pkg::STAT_OK;
   endfunction

   // expected result of one item; advances the pool model
   function automatic alloc_rsp_type pool_step(input bit act, input logic [19:0] rq,
                                               input logic [31:0] ad, input logic [20:0] bs);
      alloc_rsp_type r;
      logic [31:0] ga;
      int unsigned gs;
      ga = 0;
      gs = 0;
      if (!act) r.st = pool_alloc(rq, ga, gs);
      else      r.st = pool_free(ad, bs);
      r.ga = (r.st == ffha_pkg::STAT_OK) ? ga : 32'd0;
      r.gs = (r.st == ffha_pkg::STAT_OK) ? 21'(gs) : 21'd0;
      r.ft = 21'(free_m);
      return r;
   endfunction

   // drive one item and wait until the block takes it
   task automatic issue(input bit act, input logic [19:0] rq, input logic [31:0] ad,
                        input logic [20:0] bs, input bit typed, input alloc_rsp_type want);
      alloc_rsp_type got;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      start          <= 1'b1;
      req_action     <= act;
      req_size       <= rq;
      req_addr       <= ad;
      req_block_size <= bs;
      @(posedge clock);
      while (busy) @(posedge clock);
      got = pool_step(act, rq, ad, bs);
      rsp_q.push_back(typed ? want : got);
      n_items++;
      st_count[got.st]++;
      // keep the list of handed-out blocks in step
      if (got.st == ffha_pkg::STAT_OK) begin
         if (!act) begin
            live_addr.push_back(got.ga);
            live_size.push_back(got.gs);
         end else begin
            gone_addr = ad;
            gone_size = bs;
            foreach (live_addr[k])
               if (live_addr[k] == ad) begin
                  live_addr.delete(k);
                  live_size.delete(k);
                  break;
               end
         end
      end
   endtask

   task automatic send(input bit act, input logic [19:0] rq, input logic [31:0] ad,
                       input logic [20:0] bs);
      issue(act, rq, ad, bs, 1'b0, '0);
   endtask

   // hold the sender until every pending result is back
   task automatic drain(input int settle);
      start <= 1'b0;
      @(posedge clock);
      while (rsp_q.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic csr_write(input logic [ffha_pkg::CSR_W-1:0] idx, input logic [31:0] data);
      drain(SETTLE);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == ffha_pkg::CSR_POOL_BASE) pool_base_m = data;
      else                                pool_size_m = data[20:0];
      pool_reinit();
      live_addr.delete();
      live_size.delete();
      gone_addr = 0;
      gone_size = 0;
      repeat (2) @(posedge clock);
   endtask

   // one random item: mostly sane alloc/free traffic, some junk
   task automatic random_item();
      int sel, k;
      logic [19:0] rq;
      sel = $urandom_range(0, 99);
      if (sel < 45 || (sel < 85 && live_addr.size() == 0)) begin
         k = $urandom_range(0, 99);
         if (k < 70)      rq = 20'($urandom_range(1, 256));
         else if (k < 95) rq = 20'($urandom_range(1, 4096));
         else             rq = 20'($urandom);
         send(1'b0, rq, '0, '0);
      end else if (sel < 85) begin
         k = $urandom_range(0, live_addr.size() - 1);
         send(1'b1, 20'($urandom), live_addr[k], live_size[k]);
      end else begin
         k = $urandom_range(0, 4);
         case (k)
            0: send(1'b0, '0, $urandom, 21'($urandom));
            1: send(1'b1, 20'($urandom), $urandom, 21'($urandom));
            2: send(1'b1, '0, gone_addr, gone_size);
            3: if (live_addr.size() != 0)
                  send(1'b1, '0, live_addr[0] + 32'd4, live_size[0]);
               else
                  send(1'b1, '0, 32'($urandom_range(0, 15)), 21'($urandom_range(0, 40)));
            default: if (live_addr.size() != 0)
                  send(1'b1, '0, live_addr[0], live_size[0] + 21'd8);
               else
                  send(1'b0, 20'hFFFFF, '0, '0);
         endcase
      end
   endtask

   task automatic random_phase(input int count, input bit gaps);
      for (int n = 0; n < count; n++) begin
         idle_on = gaps && (n % 100) >= 30;
         random_item();
         if (n == count / 2) drain(0);
      end
   endtask

   // results: compare against the oldest expectation
   always @(posedge clock) begin
      alloc_rsp_type w;
      if (!reset && rsp_valid) begin
         n_results++;
         if (rsp_q.size() == 0) begin
            $display("%0t: result with nothing expected (status %0d)", $realtime, rsp_status);
            errors++;
         end else begin
            w = rsp_q.pop_front();
            if (rsp_status !== w.st) begin
               $display("%0t: status exp %0d got %0d", $realtime, w.st, rsp_status);
               errors++;
            end
            if (rsp_granted_addr !== w.ga) begin
               $display("%0t: granted_addr exp %h got %h", $realtime, w.ga, rsp_granted_addr);
               errors++;
            end
            if (rsp_granted_size !== w.gs) begin
               $display("%0t: granted_size exp %0d got %0d", $realtime, w.gs, rsp_granted_size);
               errors++;
            end
            if (rsp_free_total !== w.ft) begin
               $display("%0t: free_total exp %0d got %0d", $realtime, w.ft, rsp_free_total);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles without any item moving
   int quiet;
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
         if (quiet == WD_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   dir_row_type dir_tab[] = '{
      '{1'b0, 20'd0, 32'd0, 21'd0, 1'b1,
        '{ffha_pkg::STAT_BAD_REQ, 32'd0, 21'd0, 21'd65536}},
      '{1'b0, 20'd1, 32'd0, 21'd0, 1'b1,
        '{ffha_pkg::STAT_OK, 32'd8, 21'd16, 21'd65520}},
      '{1'b0, 20'hFFFFF, 32'd0, 21'd0, 1'b1,
        '{ffha_pkg::STAT_NO_MEM, 32'd0, 21'd0, 21'd65520}},
      '{1'b1, 20'd0, 32'd8, 21'd16, 1'b1,
        '{ffha_pkg::STAT_OK, 32'd0, 21'd0, 21'd65536}},
      '{1'b1, 20'd0, 32'd8, 21'd16, 1'b1,
        '{ffha_pkg::STAT_OVERLAP, 32'd0, 21'd0, 21'd65536}},
      '{1'b1, 20'd0, 32'd0, 21'd16, 1'b1,
        '{ffha_pkg::STAT_BAD_BLOCK, 32'd0, 21'd0, 21'd65536}},
      '{1'b1, 20'd0, 32'd12, 21'd16, 1'b1,
        '{ffha_pkg::STAT_BAD_BLOCK, 32'd0, 21'd0, 21'd65536}},
      '{1'b1, 20'd0, 32'd8, 21'd12, 1'b1,
        '{ffha_pkg::STAT_BAD_BLOCK, 32'd0, 21'd0, 21'd65536}},
      '{1'b1, 20'd0, 32'd8, 21'd8, 1'b1,
        '{ffha_pkg::STAT_BAD_BLOCK, 32'd0, 21'd0, 21'd65536}},
      '{1'b1, 20'hFFFFF, 32'hFFFFFFFF, 21'h1FFFFF, 1'b1,
        '{ffha_pkg::STAT_BAD_BLOCK, 32'd0, 21'd0, 21'd65536}},
      '{1'b1, 20'd0, 32'd65536, 21'd16, 1'b1,
        '{ffha_pkg::STAT_BAD_BLOCK, 32'd0, 21'd0, 21'd65536}},
      '{1'b0, 20'd65528, 32'd0, 21'd0, 1'b1,
        '{ffha_pkg::STAT_OK, 32'd8, 21'd65536, 21'd0}},
      '{1'b0, 20'd1, 32'd0, 21'd0, 1'b1,
        '{ffha_pkg::STAT_NO_MEM, 32'd0, 21'd0, 21'd0}},
      '{1'b1, 20'd0, 32'd8, 21'd65536, 1'b1,
        '{ffha_pkg::STAT_OK, 32'd0, 21'd0, 21'd65536}},
      '{1'b0, 20'd100,    32'd0,      21'd0,      1'b0, '0},
      '{1'b0, 20'd200,    32'd0,      21'd0,      1'b0, '0},
      '{1'b0, 20'd7,      32'd0,      21'd0,      1'b0, '0},
      '{1'b1, 20'd0,      32'd8,      21'd112,    1'b0, '0},
      '{1'b1, 20'd0,      32'd120,    21'd216,    1'b0, '0},
      '{1'b1, 20'd0,      32'd336,    21'd16,     1'b0, '0},
      '{1'b0, 20'd65513,  32'd0,      21'd0,      1'b0, '0}
   };

   initial begin
      errors = 0;
      n_items = 0;
      n_results = 0;
      idle_on = 1'b0;
      gone_addr = 0;
      gone_size = 0;
      foreach (st_count[k]) st_count[k] = 0;
      reset = 1'b1;
      start = 1'b0;
      req_action = 1'b0;
      req_size = '0;
      req_addr = '0;
      req_block_size = '0;
      csr_we = 1'b0;
      csr_index = ffha_pkg::CSR_POOL_BASE;
      csr_wdata = '0;
      pool_base_m = 32'd0;
      pool_size_m = 21'd65536;
      pool_reinit();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // directed rows from reset state
      foreach (dir_tab[k])
         issue(dir_tab[k].act, dir_tab[k].rq, dir_tab[k].ad, dir_tab[k].bs,
               dir_tab[k].typed, dir_tab[k].want);

      // fill the extent table: many tiny blocks, free every other one, then the rest
      csr_write(ffha_pkg::CSR_POOL_SIZE, 32'd65536);
      idle_on = 1'b1;
      for (int n = 0; n < 130; n++) send(1'b0, 20'($urandom_range(1, 8)), '0, '0);
      for (int n = 0; n < 130; n += 2) send(1'b1, '0, 32'(8 + 16 * n), 21'd16);
      for (int n = 1; n < 130; n += 2) send(1'b1, '0, 32'(8 + 16 * n), 21'd16);

      // random traffic over several pool geometries
      random_phase(220, 1'b1);
      csr_write(ffha_pkg::CSR_POOL_BASE, 32'h0000_0013);
      csr_write(ffha_pkg::CSR_POOL_SIZE, 32'hFFE0_1000);
      random_phase(200, 1'b1);
      csr_write(ffha_pkg::CSR_POOL_SIZE, 32'd48);
      random_phase(60, 1'b1);
      csr_write(ffha_pkg::CSR_POOL_BASE, 32'hFFFF_F000);
      csr_write(ffha_pkg::CSR_POOL_SIZE, 32'd1048576);
      random_phase(160, 1'b1);
      csr_write(ffha_pkg::CSR_POOL_BASE, 32'hFFFF_FFF9);
      random_phase(20, 1'b1);
      csr_write(ffha_pkg::CSR_POOL_BASE, $urandom & 32'h7FFF_FFFF);
      csr_write(ffha_pkg::CSR_POOL_SIZE, 32'd47);
      random_phase(20, 1'b1);
      csr_write(ffha_pkg::CSR_POOL_SIZE, 32'd0);
      random_phase(10, 1'b0);
      csr_write(ffha_pkg::CSR_POOL_BASE, {$urandom} | 32'h1);
      csr_write(ffha_pkg::CSR_POOL_SIZE, 32'd1048576);
      random_phase(200, 1'b1);
      csr_write(ffha_pkg::CSR_POOL_BASE, 32'd0);
      csr_write(ffha_pkg::CSR_POOL_SIZE, 32'd2048);
      random_phase(150, 1'b0);

      drain(SETTLE);
      $display("Ran %0d items, %0d results: ok %0d, bad request %0d, out of memory %0d,",
               n_items, n_results, st_count[ffha_pkg::STAT_OK],
               st_count[ffha_pkg::STAT_BAD_REQ], st_count[ffha_pkg::STAT_NO_MEM]);
      $display("bad block %0d, overlap %0d, table full %0d over nine pool settings",
               st_count[ffha_pkg::STAT_BAD_BLOCK], st_count[ffha_pkg::STAT_OVERLAP],
               st_count[ffha_pkg::STAT_FULL]);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/ffha_pkg.sv
rtl/core/ffha_ram.sv
rtl/core/ffha_front.sv
rtl/core/ffha_back.sv
rtl/core/first_fit_heap_allocator.sv
test/tb_top.sv
